>>> hdl/deq_pkg.sv
// Shared constants, types and ring-position helper for the double-ended queue.
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_LIST_FWD   = 3'd4,
        MODE_LIST_BWD   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } wr_port_t;

    // Ring position head + off, both below DEPTH, folded back into the ring.
    function automatic logic [ADDR_W-1:0] wrap_pos(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH))
        begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> hdl/deq_store.sv
// Entry storage of the ring: one write port, one registered read port.
module deq_store (
    input  logic                           clk,
    input  deq_pkg::wr_port_t              wr,
    input  logic [deq_pkg::ADDR_W-1:0]     rd_addr,
    output logic [deq_pkg::WORD_W-1:0]     rd_data
);

    logic [deq_pkg::WORD_W-1:0] mem [deq_pkg::DEPTH];
    logic [deq_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/double_ended_queue_unit.sv
// Top level of the double-ended queue: sequencer, ring pointers and result registers.
//
//  channel   ports                               handshake
//  command   start, busy, mode, value            taken when start && !busy
//  result    done, result_value, status, last    done marks each item
//
// Push, full push, empty pop or empty listing: result in the cycle after start, busy stays low.
// Pop: busy for one cycle; the entry passes the registered store read, then the result registers.
// Listing of N entries: busy while they are read out, one result per cycle, last on the final one.
// All ring positions come from one shared wrap adder; the store has one read port.
// Reset clears state, pointers, count and done, not the store. Results cannot be stalled.
module double_ended_queue_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] result_value,
    output logic [1:0]         status,
    output logic               last
);

    localparam int AW = deq_pkg::ADDR_W;
    localparam int CW = deq_pkg::CNT_W;

    deq_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     em_reg, em_next;
    logic              fwd_reg, fwd_next;

    logic              done_reg, done_next;
    logic [31:0]       res_reg, res_next;
    logic [1:0]        stat_reg, stat_next;
    logic              last_reg, last_next;

    logic [CW-1:0]     off_sel;
    logic [AW-1:0]     pos;
    logic [CW-1:0]     em_inc;
    logic              list_end;
    logic              full;
    logic              empty;

    deq_pkg::wr_port_t wr;
    logic [31:0]       rd_data;

    deq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (pos),
        .rd_data (rd_data)
    );

    assign pos      = deq_pkg::wrap_pos(head_reg, off_sel);
    assign full     = (count_reg == CW'(deq_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign em_inc   = em_reg + CW'(1);
    assign list_end = (em_inc == count_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        em_next    = em_reg;
        fwd_next   = fwd_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        stat_next  = stat_reg;
        last_next  = last_reg;
        off_sel    = '0;
        wr.en      = 1'b0;
        wr.addr    = pos;
        wr.data    = value;

        case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (deq_pkg::mode_t'(mode))
                        deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR:
                        begin
                            done_next = 1'b1;
                            res_next  = '0;
                            last_next = 1'b1;
                            if (full)
                            begin
                                stat_next = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                stat_next  = deq_pkg::STAT_OK;
                                wr.en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (deq_pkg::mode_t'(mode) == deq_pkg::MODE_PUSH_FRONT)
                                begin
                                    // step the head back one slot and write there
                                    off_sel   = CW'(deq_pkg::DEPTH - 1);
                                    head_next = pos;
                                end
                                else
                                begin
                                    off_sel = count_reg;
                                end
                            end
                        end
                        deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_REAR:
                        begin
                            if (empty)
                            begin
                                done_next = 1'b1;
                                res_next  = '0;
                                stat_next = deq_pkg::STAT_EMPTY;
                                last_next = 1'b1;
                            end
                            else
                            begin
                                fwd_next   = (deq_pkg::mode_t'(mode) == deq_pkg::MODE_POP_FRONT);
                                off_sel    = (deq_pkg::mode_t'(mode) == deq_pkg::MODE_POP_FRONT)
                                             ? '0 : count_reg - CW'(1);
                                count_next = count_reg - CW'(1);
                                state_next = deq_pkg::S_POP;
                            end
                        end
                        deq_pkg::MODE_LIST_FWD, deq_pkg::MODE_LIST_BWD:
                        begin
                            if (empty)
                            begin
                                done_next = 1'b1;
                                res_next  = '0;
                                stat_next = deq_pkg::STAT_EMPTY;
                                last_next = 1'b1;
                            end
                            else
                            begin
                                fwd_next   = (deq_pkg::mode_t'(mode) == deq_pkg::MODE_LIST_FWD);
                                off_sel    = (deq_pkg::mode_t'(mode) == deq_pkg::MODE_LIST_FWD)
                                             ? '0 : count_reg - CW'(1);
                                em_next    = '0;
                                state_next = deq_pkg::S_LIST;
                            end
                        end
                        default:
                        begin
                            // drop unused codes
                        end
                    endcase
                end
            end
            deq_pkg::S_POP:
            begin
                done_next  = 1'b1;
                res_next   = rd_data;
                stat_next  = deq_pkg::STAT_OK;
                last_next  = 1'b1;
                state_next = deq_pkg::S_IDLE;
                if (fwd_reg)
                begin
                    // advance the head past the removed entry
                    off_sel   = CW'(1);
                    head_next = pos;
                end
            end
            deq_pkg::S_LIST:
            begin
                done_next = 1'b1;
                res_next  = rd_data;
                stat_next = deq_pkg::STAT_OK;
                last_next = list_end;
                em_next   = em_inc;
                if (list_end)
                begin
                    state_next = deq_pkg::S_IDLE;
                end
                else
                begin
                    // prefetch the next entry while this one goes out
                    off_sel = fwd_reg ? em_inc : count_reg - CW'(1) - em_inc;
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= deq_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            em_reg    <= '0;
            fwd_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            em_reg    <= em_next;
            fwd_reg   <= fwd_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        stat_reg <= stat_next;
        last_reg <= last_next;
    end

    assign busy         = (state_reg != deq_pkg::S_IDLE);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign status       = stat_reg;
    assign last         = last_reg;

endmodule
